FILE: design/crcbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crcbs_pkg;

   // crc register value at reset and after each finished message
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
   // reflected ieee 802.3 polynomial
   localparam logic [31:0] POLY_RESET = 32'hEDB8_8320;

   localparam int DATA_WIDTH = 8;
   localparam int CRC_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // register index, taken from the word address
   typedef enum logic [0:0] {
      REG_POLYNOMIAL  = 1'b0,
      REG_FINISH_MODE = 1'b1
   } crcbs_reg_type;

   // finish modes
   typedef enum logic [0:0] {
      FINISH_COMPLEMENT = 1'b0,
      FINISH_REVERSE    = 1'b1
   } crcbs_finish_type;

   // one input item
   typedef struct packed {
      logic [DATA_WIDTH-1:0] data_byte;
      logic                  byte_valid;
      logic                  last;
   } crcbs_item_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [CRC_WIDTH-1:0] polynomial;
      crcbs_finish_type     finish_mode;
   } crcbs_cfg_type;

   // bit reversal of a crc word
   function automatic logic [CRC_WIDTH-1:0] reverse_crc(input logic [CRC_WIDTH-1:0] x);
      logic [CRC_WIDTH-1:0] r;
      for (int k = 0; k < CRC_WIDTH; k++) begin
         r[k] = x[CRC_WIDTH-1-k];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/crcbs_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module crcbs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crcbs_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [crcbs_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [crcbs_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output crcbs_pkg::crcbs_cfg_type             cfg
);
   import crcbs_pkg::*;

   logic [CRC_WIDTH-1:0] polynomial_ff;
   logic [CRC_WIDTH-1:0] polynomial_in;
   crcbs_finish_type     finish_mode_ff;
   crcbs_finish_type     finish_mode_in;
   crcbs_reg_type        reg_sel;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel = crcbs_reg_type'(csr_paddr[2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register writes
   always_comb begin
      polynomial_in = polynomial_ff;
      finish_mode_in = finish_mode_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_POLYNOMIAL:  polynomial_in = csr_pwdata;
            REG_FINISH_MODE: finish_mode_in = crcbs_finish_type'(csr_pwdata[0]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         polynomial_ff <= POLY_RESET;
         finish_mode_ff <= FINISH_COMPLEMENT;
      end else begin
         polynomial_ff <= polynomial_in;
         finish_mode_ff <= finish_mode_in;
      end
   end

   // register reads
   always_comb begin
      unique case (reg_sel)
         REG_POLYNOMIAL:  csr_prdata = polynomial_ff;
         REG_FINISH_MODE: csr_prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, finish_mode_ff};
      endcase
   end

   assign cfg.polynomial = polynomial_ff;
   assign cfg.finish_mode = finish_mode_ff;

endmodule

`default_nettype wire

FILE: design/crcbs_fold.sv
`timescale 1ns / 1ps
`default_nettype none

module crcbs_fold (
   input  logic [crcbs_pkg::CRC_WIDTH-1:0] crc_cur,
   input  crcbs_pkg::crcbs_item_type       item,
   input  crcbs_pkg::crcbs_cfg_type        cfg,
   output logic [crcbs_pkg::CRC_WIDTH-1:0] crc_next,
   output logic [crcbs_pkg::CRC_WIDTH-1:0] crc_result
);
   import crcbs_pkg::*;

   logic [CRC_WIDTH-1:0] folded;

   // eight lsb-first shift steps over the byte
   always_comb begin
      folded = crc_cur;
      if (item.byte_valid) begin
         for (int k = 0; k < DATA_WIDTH; k++) begin
            if (folded[0] ^ item.data_byte[k]) begin
               folded = (folded >> 1) ^ cfg.polynomial;
            end else begin
               folded = folded >> 1;
            end
         end
      end
   end

   // finish the message per mode
   always_comb begin
      unique case (cfg.finish_mode)
         FINISH_COMPLEMENT: crc_result = ~folded;
         FINISH_REVERSE:    crc_result = reverse_crc(folded);
      endcase
   end

   // register restarts after the closing item
   assign crc_next = item.last ? CRC_ALL_ONES : folded;

endmodule

`default_nettype wire

FILE: design/crc32_byte_stream_two_finish_modes.sv
`timescale 1ns / 1ps
`default_nettype none

// Reflected 32-bit CRC over a byte stream. Each request item carries one byte
// (tdata), a byte-valid flag (tuser) and an end-of-message mark (tlast); an item
// with tuser low adds no byte, and with tlast high it still closes the message.
// Only items with tlast produce a response item, carrying the finished CRC:
// the complemented register (finish_mode 0) or the bit-reversed register
// (finish_mode 1). The block takes one item every clock cycle while it is not
// stalled. A response is valid once its closing item has been captured in the
// input register and the eight-step fold has landed in the result register. A
// closing item waits in the input register while an earlier response is still
// held, which stalls the request side until it is taken.
// The polynomial and finish mode sit at byte addresses 0x0 and 0x4 and should
// be written only while idle.
module crc32_byte_stream_two_finish_modes (
   input  logic                                clock,
   input  logic                                reset,
   // request item
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // data_byte[7:0]
   input  logic                                req_tuser,   // byte_valid
   input  logic                                req_tlast,   // last
   // response item
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,   // crc_value[31:0]
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crcbs_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [crcbs_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [crcbs_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import crcbs_pkg::*;

   crcbs_cfg_type        cfg;
   crcbs_item_type       item_ff;
   crcbs_item_type       item_in;
   logic                 item_valid_ff;
   logic                 item_valid_in;
   logic [CRC_WIDTH-1:0] crc_ff;
   logic [CRC_WIDTH-1:0] crc_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [CRC_WIDTH-1:0] out_crc_ff;
   logic [CRC_WIDTH-1:0] out_crc_in;
   logic [CRC_WIDTH-1:0] crc_next;
   logic [CRC_WIDTH-1:0] crc_result;
   logic                 advance;
   logic                 finish;

   crcbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   crcbs_fold u_fold (
      .crc_cur    (crc_ff),
      .item       (item_ff),
      .cfg        (cfg),
      .crc_next   (crc_next),
      .crc_result (crc_result)
   );

   // an item leaves the input register unless it closes a message and the
   // result slot is still held
   assign advance = item_valid_ff & (~item_ff.last | ~out_valid_ff | rsp_tready);
   assign finish = advance & item_ff.last;
   assign req_tready = ~item_valid_ff | advance;

   // input register
   always_comb begin
      item_valid_in = item_valid_ff;
      item_in = item_ff;
      if (req_tready) begin
         item_valid_in = req_tvalid;
         item_in.data_byte = req_tdata;
         item_in.byte_valid = req_tuser;
         item_in.last = req_tlast;
      end
   end

   // crc register and result register
   always_comb begin
      crc_in = crc_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_crc_in = out_crc_ff;
      if (advance) begin
         crc_in = crc_next;
      end
      if (finish) begin
         out_valid_in = 1'b1;
         out_crc_in = crc_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         crc_ff <= CRC_ALL_ONES;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff <= out_valid_in;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_crc_ff <= out_crc_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_crc_ff;

`ifndef SYNTHESIS
   // the crc register restarts after every closing item
   a_restart: assert property (@(posedge clock) disable iff (reset)
      finish |=> crc_ff == CRC_ALL_ONES)
      else $error("crc register not restarted after closing item");

   // an item with no byte and no end mark leaves the crc untouched
   a_idle_item: assert property (@(posedge clock) disable iff (reset)
      advance && !item_ff.byte_valid && !item_ff.last |=> $stable(crc_ff))
      else $error("crc changed on an empty item");

   // a new result only comes from a closing item
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(finish))
      else $error("result raised without a closing item");

   // a closing item never overwrites a result still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      finish |-> !out_valid_ff || rsp_tready)
      else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire
